[rtl/core/mavg_pkg.sv]
package mavg_pkg;

  localparam int WINDOW   = 16;
  localparam int SAMPLE_W = 16;
  localparam int HELD_W   = 5;
  localparam int PTR_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W    = $clog2(WINDOW + 1);
  localparam int SUM_W    = SAMPLE_W + PTR_W;
  localparam int STEP_W   = $clog2(SUM_W);

  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic [CNT_W-1:0]           count_t;
  typedef logic [PTR_W-1:0]           ptr_t;

  typedef struct packed {
    logic   start;
    sum_t   dividend;
    count_t divisor;
  } div_req_t;

  typedef struct packed {
    logic    done;
    sample_t quotient;
  } div_rsp_t;

endpackage

[rtl/core/mavg_if.sv]
interface mavg_in_if
  import mavg_pkg::*;
;
  logic    valid;
  logic    ready;
  logic    opcode;
  sample_t sample;

  modport source (output valid, output opcode, output sample, input ready);
  modport sink (input valid, input opcode, input sample, output ready);
endinterface

interface mavg_out_if
  import mavg_pkg::*;
;
  logic              valid;
  logic              ready;
  sample_t           average;
  logic [HELD_W-1:0] held_count;

  modport source (output valid, output average, output held_count, input ready);
  modport sink (input valid, input average, input held_count, output ready);
endinterface

[rtl/core/mavg_div.sv]
module mavg_div
  import mavg_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic               busy;
  logic               done;
  logic               neg;
  logic [STEP_W-1:0]  step;
  logic [SUM_W-1:0]   quo;
  count_t             rem;
  count_t             divisor;

  logic [CNT_W:0]     trial;
  logic               fits;
  logic [CNT_W:0]     diff;
  logic [SUM_W-1:0]   signed_quo;

  // One quotient bit per cycle, restoring division on the magnitude.
  always_comb begin
    trial = {rem, quo[SUM_W-1]};
    fits  = (trial >= {1'b0, divisor});
    diff  = trial - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !req.start && (step == '0);
      if (req.start) begin
        busy    <= 1'b1;
        neg     <= req.dividend[SUM_W-1];
        quo     <= req.dividend[SUM_W-1] ? SUM_W'(-req.dividend) : SUM_W'(req.dividend);
        rem     <= '0;
        divisor <= req.divisor;
        step    <= STEP_W'(SUM_W - 1);
      end else if (busy) begin
        rem  <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        quo  <= {quo[SUM_W-2:0], fits};
        step <= step - 1'b1;
        if (step == '0) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Negating the magnitude gives truncation toward zero.
  assign signed_quo   = neg ? (~quo + 1'b1) : quo;
  assign rsp.done     = done;
  assign rsp.quotient = signed_quo[SAMPLE_W-1:0];

endmodule

[rtl/core/moving_average_filter.sv]
// Boxcar moving average over the last WINDOW samples (16 here). Each input
// word either pushes a signed Q8.8 sample or clears the filter; every word
// yields one result word with the mean of the held samples, truncated toward
// zero, and the number of samples held (0 gives a mean of 0). Samples live in
// a single-port RAM of WINDOW entries with a registered read; a running
// sum is kept in a register and divided by the count in a bit-serial
// divider. A push goes from acceptance to result in order: the RAM read of
// the oldest sample overlaps the acceptance, then one read-modify-write of
// the sum, SUM_W divider steps, a registered done flag from the divider, and
// the output load, which waits until the output register is free. A clear
// resets the pointer, count and sum and goes straight to the output load.
// The block works on one word at a time; a finished result waits in an
// output register while the next word is accepted. No clearing pass is needed
// after reset, since an entry is read back only once the ring is full again.
module moving_average_filter
  import mavg_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  mavg_in_if.sink      samples,
  mavg_out_if.source   results
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPDATE,
    S_DIV,
    S_DONE
  } state_t;

  state_t   state;
  logic     op_q;
  sample_t  sample_q;
  logic     zero_q;
  ptr_t     wp;
  count_t   count;
  sum_t     sum;

  sample_t  mem [WINDOW];
  sample_t  rdata;

  logic     full;
  sum_t     sum_next;
  count_t   count_next;
  ptr_t     wp_next;
  logic     mem_we;
  logic     out_free;

  div_req_t div_req;
  div_rsp_t div_rsp;

  always_comb begin
    full       = (count == count_t'(WINDOW));
    sum_next   = sum - (full ? SUM_W'(rdata) : '0) + SUM_W'(sample_q);
    count_next = full ? count : count + 1'b1;
    wp_next    = (wp == ptr_t'(WINDOW - 1)) ? '0 : wp + 1'b1;
    mem_we     = (state == S_UPDATE) && (op_q == OP_PUSH);
    out_free   = !results.valid || results.ready;

    div_req.start    = mem_we;
    div_req.dividend = sum_next;
    div_req.divisor  = count_next;
  end

  assign samples.ready = (state == S_IDLE);

  // The read address is the write pointer, which stays put until the
  // update cycle, so the oldest sample is ready when it is needed.
  always_ff @(posedge clk) begin
    rdata <= mem[wp];
    if (mem_we) begin
      mem[wp] <= sample_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      wp            <= '0;
      count         <= '0;
      sum           <= '0;
      results.valid <= 1'b0;
    end else begin
      if (results.valid && results.ready && (state != S_DONE)) begin
        results.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (samples.valid) begin
            op_q     <= samples.opcode;
            sample_q <= samples.sample;
            state    <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (op_q == OP_CLEAR) begin
            wp     <= '0;
            count  <= '0;
            sum    <= '0;
            zero_q <= 1'b1;
            state  <= S_DONE;
          end else begin
            wp     <= wp_next;
            count  <= count_next;
            sum    <= sum_next;
            zero_q <= 1'b0;
            state  <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            results.valid      <= 1'b1;
            results.average    <= zero_q ? '0 : div_rsp.quotient;
            results.held_count <= HELD_W'(count);
            state              <= S_IDLE;
          end else if (results.valid && results.ready) begin
            results.valid <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  mavg_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

endmodule
